// File: src/ttc_pkg.sv
package ttc_pkg;

   localparam int ROM_SIZE = 165;
   localparam int RES_BITS = 22;
   localparam logic [11:0] WIN_LOW_MV = 12'd300;
   localparam logic [11:0] WIN_HIGH_MV = 12'd1250;
   localparam logic signed [7:0] FAKE_TEMP = 8'sd25;
   localparam logic signed [7:0] BASE_TEMP = -8'sd40;

   localparam logic [1:0] CSR_TRIP_LOW = 2'd0;
   localparam logic [1:0] CSR_TRIP_MID = 2'd1;
   localparam logic [1:0] CSR_TRIP_HIGH = 2'd2;

   typedef logic [RES_BITS-1:0] res_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;      // latch reading and start
      logic div_step;  // one restoring division step
      logic rom_step;  // compare one table entry
      logic finish;    // build result word
   } ttc_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic in_window;
      logic last_bias;
      logic div_last;
      logic rom_hit;
      logic rom_last;
   } ttc_stat_type;

   function automatic logic [5:0] bias_ua(input logic [2:0] idx);
      logic [5:0] b;
      begin
         case (idx)
            3'd0: b = 6'd31;
            3'd1: b = 6'd61;
            3'd2: b = 6'd16;
            3'd3: b = 6'd11;
            default: b = 6'd6;
         endcase
         return b;
      end
   endfunction

   function automatic logic [12:0] poll_ms(input logic [1:0] lvl);
      logic [12:0] p;
      begin
         case (lvl)
            2'd0: p = 13'd5000;
            2'd1: p = 13'd4000;
            2'd2: p = 13'd3000;
            default: p = 13'd2000;
         endcase
         return p;
      end
   endfunction

   function automatic res_type res_rom(input logic [7:0] i);
      res_type r;
      begin
         case (i)
            8'd0: r = 1747919; 8'd1: r = 1631671; 8'd2: r = 1523950; 8'd3: r = 1424075;
            8'd4: r = 1331424; 8'd5: r = 1245427; 8'd6: r = 1165564; 8'd7: r = 1091357;
            8'd8: r = 1022369; 8'd9: r = 958201; 8'd10: r = 898485; 8'd11: r = 842883;
            8'd12: r = 791087; 8'd13: r = 742813; 8'd14: r = 697798; 8'd15: r = 655802;
            8'd16: r = 616604; 8'd17: r = 580001; 8'd18: r = 545804; 8'd19: r = 513842;
            8'd20: r = 483953; 8'd21: r = 455992; 8'd22: r = 429821; 8'd23: r = 405317;
            8'd24: r = 382362; 8'd25: r = 360849; 8'd26: r = 340680; 8'd27: r = 321762;
            8'd28: r = 304010; 8'd29: r = 287346; 8'd30: r = 271697; 8'd31: r = 256994;
            8'd32: r = 243176; 8'd33: r = 230183; 8'd34: r = 217962; 8'd35: r = 206463;
            8'd36: r = 195624; 8'd37: r = 185419; 8'd38: r = 175807; 8'd39: r = 166751;
            8'd40: r = 158214; 8'd41: r = 150165; 8'd42: r = 142572; 8'd43: r = 135408;
            8'd44: r = 128645; 8'd45: r = 122259; 8'd46: r = 116227; 8'd47: r = 110527;
            8'd48: r = 105139; 8'd49: r = 100045; 8'd50: r = 95226; 8'd51: r = 90667;
            8'd52: r = 86351; 8'd53: r = 82266; 8'd54: r = 78396; 8'd55: r = 74730;
            8'd56: r = 71255; 8'd57: r = 67962; 8'd58: r = 64838; 8'd59: r = 61875;
            8'd60: r = 59064; 8'd61: r = 56396; 8'd62: r = 53862; 8'd63: r = 51456;
            8'd64: r = 49171; 8'd65: r = 47000; 8'd66: r = 44936; 8'd67: r = 42973;
            8'd68: r = 41107; 8'd69: r = 39332; 8'd70: r = 37643; 8'd71: r = 36035;
            8'd72: r = 34504; 8'd73: r = 33046; 8'd74: r = 31657; 8'd75: r = 30333;
            8'd76: r = 29073; 8'd77: r = 27871; 8'd78: r = 26726; 8'd79: r = 25633;
            8'd80: r = 24590; 8'd81: r = 23596; 8'd82: r = 22646; 8'd83: r = 21740;
            8'd84: r = 20874; 8'd85: r = 20047; 8'd86: r = 19258; 8'd87: r = 18503;
            8'd88: r = 17781; 8'd89: r = 17092; 8'd90: r = 16432; 8'd91: r = 15801;
            8'd92: r = 15198; 8'd93: r = 14620; 8'd94: r = 14067; 8'd95: r = 13538;
            8'd96: r = 13031; 8'd97: r = 12546; 8'd98: r = 12081; 8'd99: r = 11636;
            8'd100: r = 11209; 8'd101: r = 10800; 8'd102: r = 10409; 8'd103: r = 10033;
            8'd104: r = 9673; 8'd105: r = 9327; 8'd106: r = 8996; 8'd107: r = 8678;
            8'd108: r = 8372; 8'd109: r = 8079; 8'd110: r = 7797; 8'd111: r = 7526;
            8'd112: r = 7266; 8'd113: r = 7016; 8'd114: r = 6775; 8'd115: r = 6544;
            8'd116: r = 6322; 8'd117: r = 6109; 8'd118: r = 5904; 8'd119: r = 5707;
            8'd120: r = 5517; 8'd121: r = 5335; 8'd122: r = 5160; 8'd123: r = 4992;
            8'd124: r = 4829; 8'd125: r = 4673; 8'd126: r = 4522; 8'd127: r = 4377;
            8'd128: r = 4236; 8'd129: r = 4101; 8'd130: r = 3971; 8'd131: r = 3846;
            8'd132: r = 3725; 8'd133: r = 3608; 8'd134: r = 3496; 8'd135: r = 3387;
            8'd136: r = 3283; 8'd137: r = 3183; 8'd138: r = 3086; 8'd139: r = 2992;
            8'd140: r = 2901; 8'd141: r = 2814; 8'd142: r = 2730; 8'd143: r = 2648;
            8'd144: r = 2570; 8'd145: r = 2494; 8'd146: r = 2420; 8'd147: r = 2349;
            8'd148: r = 2280; 8'd149: r = 2213; 8'd150: r = 2149; 8'd151: r = 2087;
            8'd152: r = 2027; 8'd153: r = 1969; 8'd154: r = 1913; 8'd155: r = 1859;
            8'd156: r = 1807; 8'd157: r = 1757; 8'd158: r = 1708; 8'd159: r = 1661;
            8'd160: r = 1615; 8'd161: r = 1570; 8'd162: r = 1527; 8'd163: r = 1485;
            8'd164: r = 1445;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

// File: src/thermistor_trip_classifier_core.sv
// An out-of-window word goes from the window check straight to the result; an
// in-window word takes 22 restoring divide steps, then one table entry per cycle.
// Throughput: one word at a time; no new word is taken until the result has
// been accepted. Reset: synchronous, active high; clears bias index, last
// level, hit counts and loads trip registers with 40, 50 and 55 C.
module thermistor_trip_classifier_core #(
   parameter int TABLE_ENTRIES = 165,
   parameter int BIAS_STEPS = 5,
   parameter int HIT_COUNT_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [11:0]               req_volt_mv,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_done_res,
   output logic [2:0]                rsp_next_bias_sel,
   output logic signed [7:0]         rsp_temperature_deg,
   output logic                      rsp_fake_reading,
   output logic [1:0]                rsp_trip_level,
   output logic                      rsp_level_changed,
   output logic [12:0]               rsp_poll_interval_ms,
   output logic [HIT_COUNT_BITS-1:0] rsp_hit_count,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [7:0]                csr_data
);

   ttc_pkg::ttc_cmd_type  cmd;
   ttc_pkg::ttc_stat_type stat;
   logic signed [7:0] trip_low_ff, trip_mid_ff, trip_high_ff;

   // Write trip registers
   always_ff @(posedge clock) begin
      if (reset) begin
         trip_low_ff <= 8'sd40;
         trip_mid_ff <= 8'sd50;
         trip_high_ff <= 8'sd55;
      end else if (csr_write) begin
         unique case (csr_index)
            ttc_pkg::CSR_TRIP_LOW: trip_low_ff <= csr_data;
            ttc_pkg::CSR_TRIP_MID: trip_mid_ff <= csr_data;
            ttc_pkg::CSR_TRIP_HIGH: trip_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ttc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd)
   );

   ttc_datapath #(
      .TABLE_ENTRIES(TABLE_ENTRIES), .BIAS_STEPS(BIAS_STEPS),
      .HIT_COUNT_BITS(HIT_COUNT_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_volt_mv(req_volt_mv),
      .trip_low(trip_low_ff), .trip_mid(trip_mid_ff), .trip_high(trip_high_ff),
      .rsp_done_res(rsp_done_res), .rsp_next_bias_sel(rsp_next_bias_sel),
      .rsp_temperature_deg(rsp_temperature_deg), .rsp_fake_reading(rsp_fake_reading),
      .rsp_trip_level(rsp_trip_level), .rsp_level_changed(rsp_level_changed),
      .rsp_poll_interval_ms(rsp_poll_interval_ms), .rsp_hit_count(rsp_hit_count)
   );

`ifndef NO_ASSERTIONS
   // a request for the next bias carries no temperature result
   a_req_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_trip_level == 2'd0 && rsp_hit_count == '0)
      else $error("bias request with result data");
   // the block takes no word while a result waits
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("word accepted while result pending");
   // a level-zero result never reports a hit count
   a_lvl0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_trip_level == 2'd0 |-> rsp_hit_count == '0)
      else $error("hit count on level zero");
`endif

endmodule

// File: src/ttc_ctrl.sv
module ttc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  ttc_pkg::ttc_stat_type stat,
   output ttc_pkg::ttc_cmd_type  cmd
);

   typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_DIV, ST_ROM, ST_FINISH, ST_OUT}
      state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // Issue datapath commands per state
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.in_window) state_in = ST_DIV;
            else begin
               cmd.finish = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_ROM;
         end
         ST_ROM: begin
            cmd.rom_step = 1'b1;
            if (stat.rom_hit || stat.rom_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// File: src/ttc_datapath.sv
module ttc_datapath #(
   parameter int TABLE_ENTRIES = 165,
   parameter int BIAS_STEPS = 5,
   parameter int HIT_COUNT_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ttc_pkg::ttc_cmd_type       cmd,
   output ttc_pkg::ttc_stat_type      stat,
   input  logic [11:0]                req_volt_mv,
   input  logic signed [7:0]          trip_low,
   input  logic signed [7:0]          trip_mid,
   input  logic signed [7:0]          trip_high,
   output logic                       rsp_done_res,
   output logic [2:0]                 rsp_next_bias_sel,
   output logic signed [7:0]          rsp_temperature_deg,
   output logic                       rsp_fake_reading,
   output logic [1:0]                 rsp_trip_level,
   output logic                       rsp_level_changed,
   output logic [12:0]                rsp_poll_interval_ms,
   output logic [HIT_COUNT_BITS-1:0]  rsp_hit_count
);

   localparam int N_SRCH = (TABLE_ENTRIES < ttc_pkg::ROM_SIZE) ?
                           TABLE_ENTRIES : ttc_pkg::ROM_SIZE;
   localparam int DIV_STEPS = ttc_pkg::RES_BITS;
   localparam logic [HIT_COUNT_BITS-1:0] CMAX = '1;

   logic [11:0]  mv_ff;
   logic [2:0]   bias_ff, bias_in;
   logic [1:0]   last_ff;
   logic [HIT_COUNT_BITS-1:0] hits_ff [3];
   // dividend shift, partial remainder, quotient
   logic [ttc_pkg::RES_BITS-1:0] num_ff, quo_ff;
   logic [6:0]   rem_ff;
   logic [4:0]   dcnt_ff;
   logic [7:0]   idx_ff;
   logic         in_win;
   logic [6:0]   rem_sh;
   logic [5:0]   divisor;
   logic [ttc_pkg::RES_BITS-1:0] rom_val;

   assign in_win = (mv_ff > ttc_pkg::WIN_LOW_MV) && (mv_ff < ttc_pkg::WIN_HIGH_MV);
   assign divisor = ttc_pkg::bias_ua(bias_ff);
   assign rem_sh = {rem_ff[5:0], num_ff[ttc_pkg::RES_BITS-1]};
   assign rom_val = ttc_pkg::res_rom(idx_ff);

   assign stat.in_window = in_win;
   assign stat.last_bias = ({1'b0, bias_ff} + 4'd1) >= 4'(BIAS_STEPS);
   assign stat.div_last = (dcnt_ff == 5'(DIV_STEPS - 1));
   assign stat.rom_hit = (quo_ff >= rom_val);
   assign stat.rom_last = (idx_ff == 8'(N_SRCH - 1));

   assign bias_in = bias_ff + 3'd1;

   // Division and table walk
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mv_ff <= req_volt_mv;
         num_ff <= {10'd0, req_volt_mv} * 22'd1000;
         rem_ff <= '0;
         quo_ff <= '0;
         dcnt_ff <= '0;
         idx_ff <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[ttc_pkg::RES_BITS-2:0], 1'b0};
         dcnt_ff <= dcnt_ff + 5'd1;
         if (rem_sh >= {1'b0, divisor}) begin
            rem_ff <= rem_sh - {1'b0, divisor};
            quo_ff <= {quo_ff[ttc_pkg::RES_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[ttc_pkg::RES_BITS-2:0], 1'b0};
         end
      end
      if (cmd.rom_step && !stat.rom_hit && !stat.rom_last) idx_ff <= idx_ff + 8'd1;
   end

   // Classify and update state
   logic signed [7:0] temp;
   logic fake;
   logic [1:0] lvl;
   logic [HIT_COUNT_BITS-1:0] cnt_inc;
   always_comb begin
      fake = !in_win;
      temp = fake ? ttc_pkg::FAKE_TEMP : (ttc_pkg::BASE_TEMP + $signed(idx_ff));
      if (temp >= trip_high) lvl = 2'd3;
      else if (temp >= trip_mid) lvl = 2'd2;
      else if (temp >= trip_low) lvl = 2'd1;
      else lvl = 2'd0;
      cnt_inc = '0;
      if (lvl != 2'd0) begin
         cnt_inc = hits_ff[lvl - 2'd1];
         if (cnt_inc != CMAX) cnt_inc = cnt_inc + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
         last_ff <= '0;
         for (int k = 0; k < 3; k++) hits_ff[k] <= '0;
      end else if (cmd.finish) begin
         if (!in_win && !stat.last_bias) begin
            bias_ff <= bias_in;
            rsp_done_res <= 1'b0;
            rsp_next_bias_sel <= bias_in;
            rsp_temperature_deg <= '0;
            rsp_fake_reading <= 1'b0;
            rsp_trip_level <= '0;
            rsp_level_changed <= 1'b0;
            rsp_poll_interval_ms <= '0;
            rsp_hit_count <= '0;
         end else begin
            bias_ff <= '0;
            last_ff <= lvl;
            if (lvl != 2'd0) hits_ff[lvl - 2'd1] <= cnt_inc;
            rsp_done_res <= 1'b1;
            rsp_next_bias_sel <= '0;
            rsp_temperature_deg <= temp;
            rsp_fake_reading <= fake;
            rsp_trip_level <= lvl;
            rsp_level_changed <= (lvl != last_ff);
            rsp_poll_interval_ms <= ttc_pkg::poll_ms(lvl);
            rsp_hit_count <= cnt_inc;
         end
      end
   end

endmodule
